### src/vlr_pkg.sv
// Shared types, constants and saturation helpers for the van Leer ring face value block.
package vlr_pkg;

    localparam int MUL_STEPS = 33;
    localparam int DIV_STEPS = 65;
    localparam int STEP_W    = 7;

    localparam logic [1:0] REG_CELL_WIDTH     = 2'd0;
    localparam logic [1:0] REG_INV_CELL_WIDTH = 2'd1;
    localparam logic [1:0] REG_TIME_STEP      = 2'd2;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } arith_req_t;

    function automatic logic signed [31:0] sat_mag(input logic [49:0] m, input logic neg);
        logic [49:0] lim;
        lim = neg ? 50'h0_8000_0000 : 50'h0_7FFF_FFFF;
        if (m > lim)
        begin
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return neg ? -m[31:0] : m[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sum(input logic signed [50:0] v);
        if (v > 51'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -51'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

### src/vlr_ram.sv
// Generic single-write, single-read memory with registered read data.
module vlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### src/vlr_arith.sv
// Shared iterative unit: shift-add multiplier and restoring divider, one bit per cycle.
module vlr_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  vlr_pkg::arith_req_t req,
    input  logic [64:0]         opa,
    input  logic [33:0]         opb,
    output logic                done,
    output logic [65:0]         result
);

    logic                       run_reg;
    logic                       done_reg;
    vlr_pkg::op_t               op_reg;
    logic [vlr_pkg::STEP_W-1:0] cnt_reg;
    logic [65:0]                acc_reg;
    logic [65:0]                sh_reg;
    logic [33:0]                b_reg;
    logic [34:0]                rem_reg;

    logic [65:0] acc_next;
    logic [34:0] rem_shift;
    logic [34:0] rem_diff;
    logic        rem_ge;

    always_comb
    begin
        acc_next  = acc_reg + sh_reg;
        rem_shift = {rem_reg[33:0], sh_reg[64]};
        rem_ge    = rem_shift >= {1'b0, b_reg};
        rem_diff  = rem_shift - {1'b0, b_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= vlr_pkg::OP_MUL;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            sh_reg   <= '0;
            b_reg    <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg  <= req.op;
                run_reg <= 1'b1;
                b_reg   <= opb;
                if (req.op == vlr_pkg::OP_MUL)
                begin
                    acc_reg <= '0;
                    sh_reg  <= {33'b0, opa[32:0]};
                    cnt_reg <= vlr_pkg::STEP_W'(vlr_pkg::MUL_STEPS);
                end
                else
                begin
                    rem_reg <= '0;
                    sh_reg  <= {1'b0, opa};
                    cnt_reg <= vlr_pkg::STEP_W'(vlr_pkg::DIV_STEPS);
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vlr_pkg::STEP_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                case (op_reg)
                    vlr_pkg::OP_MUL:
                    begin
                        if (b_reg[0])
                        begin
                            acc_reg <= acc_next;
                        end
                        sh_reg <= {sh_reg[64:0], 1'b0};
                        b_reg  <= {1'b0, b_reg[33:1]};
                    end
                    vlr_pkg::OP_DIV:
                    begin
                        rem_reg <= rem_ge ? rem_diff : rem_shift;
                        sh_reg  <= {1'b0, sh_reg[63:0], rem_ge};
                    end
                    default:
                    begin
                        b_reg <= b_reg;
                    end
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == vlr_pkg::OP_DIV) ? {1'b0, sh_reg[64:0]} : acc_reg;

endmodule

### src/van_leer_ring_face_values.sv
// Top level: loads one ring of cells, computes van Leer slopes, then emits upwinded face values.
// Loading takes one cycle per cell beat; the ring ends at the flagged cell or when the ring is full.
// Each slope, when both neighbor differences share a sign, takes five states of reads and sign test,
// a 33-step multiply, a 65-step divide and a 33-step multiply; otherwise it takes the five states alone.
// Each face value takes three reads, two 33-step multiplies and one output state that waits out
// output stalls, all on one shared bit-serial unit. One ring at a time; no cell beat is taken
// until the last face beat is taken.
// Reset clears control state and sets the registers to 1.0; the ring memories are not cleared.
module van_leer_ring_face_values #(
    parameter int RING_CELLS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cell_valid,
    output logic               cell_stall,
    input  logic signed [31:0] cell_value,
    input  logic signed [31:0] cell_velocity,
    input  logic               last_cell,
    output logic               face_valid,
    input  logic               face_stall,
    output logic signed [31:0] face_value,
    output logic [5:0]         cell_index,
    output logic               last_face,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = $clog2(RING_CELLS);
    localparam int CW = $clog2(RING_CELLS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_SL_A, S_SL_B, S_SL_C, S_SL_D, S_SL_E, S_SL_MUL1, S_SL_DIV, S_SL_MUL2,
        S_FA_A, S_FA_B, S_FA_C, S_FA_KSI, S_FA_MUL, S_FA_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] fill_reg;
    logic [AW-1:0] j_reg;
    logic [30:0] cw_reg, icw_reg, dt_reg;
    logic signed [31:0] qm_reg, qc_reg, sm_reg, sc_reg, v_reg, base_reg;
    logic [32:0] um_reg, up_reg;
    logic neg_reg, ok_reg;
    logic out_valid_reg, out_last_reg;
    logic signed [31:0] out_face_reg;
    logic [5:0] out_idx_reg;

    vlr_pkg::arith_req_t req;
    logic [64:0] opa;
    logic [33:0] opb;
    logic ar_done;
    logic [65:0] ar_res;

    logic [AW-1:0] jm, jp, val_raddr, slp_raddr;
    logic [31:0] val_rdata, vel_rdata, slp_rdata, slp_wdata;
    logic slp_we, accept, j_last;
    logic [CW-1:0] fill_next;
    logic signed [32:0] dm, dp;
    logic signed [31:0] ksi, sel_sl, slope_val, face_sum;
    logic signed [33:0] t34;
    logic [32:0] t_mag, sl_mag;
    logic face_neg, ksi_pos;
    logic [50:0] p_ext;

    assign accept     = cell_valid && !cell_stall;
    assign cell_stall = (state_reg != S_LOAD);
    assign cfg_ready  = 1'b1;
    assign fill_next  = fill_reg + 1'b1;
    assign j_last     = (CW'(j_reg) + CW'(1)) == fill_reg;
    assign jm         = (j_reg == '0) ? AW'(fill_reg - 1'b1) : j_reg - 1'b1;
    assign jp         = j_last ? '0 : j_reg + 1'b1;

    always_comb
    begin
        dm        = 33'(qc_reg) - 33'(qm_reg);
        dp        = 33'(signed'(val_rdata)) - 33'(qc_reg);
        ksi       = vlr_pkg::sat_mag(ar_res[65:16], v_reg[31]);
        ksi_pos   = (ksi > 32'sd0);
        t34       = ksi_pos ? (34'({3'b0, cw_reg}) - 34'(ksi)) : (34'({3'b0, cw_reg}) + 34'(ksi));
        sel_sl    = ksi_pos ? sm_reg : sc_reg;
        t_mag     = t34[33] ? 33'(-t34) : t34[32:0];
        sl_mag    = sel_sl[31] ? 33'(-34'(sel_sl)) : {1'b0, sel_sl};
        face_neg  = t34[33] ^ sel_sl[31] ^ !ksi_pos;
        slope_val = vlr_pkg::sat_mag(ar_res[65:16], neg_reg);
        p_ext     = {1'b0, ar_res[65:16]};
        face_sum  = vlr_pkg::sat_sum(51'(base_reg) + (neg_reg ? -p_ext : p_ext));

        req       = '{start: 1'b0, op: vlr_pkg::OP_MUL};
        opa       = '0;
        opb       = '0;
        slp_we    = 1'b0;
        slp_wdata = '0;
        val_raddr = j_reg;
        slp_raddr = j_reg;
        case (state_reg)
            S_SL_A: val_raddr = jm;
            S_SL_C: val_raddr = jp;
            S_FA_A:
            begin
                val_raddr = jm;
                slp_raddr = jm;
            end
            S_SL_E:
            begin
                if (ok_reg)
                begin
                    req.start = 1'b1;
                    opa       = {32'b0, um_reg};
                    opb       = {1'b0, up_reg};
                end
                else
                begin
                    slp_we = 1'b1;
                end
            end
            S_SL_MUL1:
            begin
                req = '{start: ar_done, op: vlr_pkg::OP_DIV};
                opa = ar_res[64:0];
                opb = {1'b0, um_reg} + {1'b0, up_reg};
            end
            S_SL_DIV:
            begin
                req.start = ar_done;
                opa       = {32'b0, ar_res[32:0]};
                opb       = {3'b0, icw_reg};
            end
            S_SL_MUL2:
            begin
                slp_we    = ar_done;
                slp_wdata = slope_val;
            end
            S_FA_C:
            begin
                req.start = 1'b1;
                opa       = {33'b0, v_reg[31] ? -v_reg : v_reg};
                opb       = {3'b0, dt_reg};
            end
            S_FA_KSI:
            begin
                req.start = ar_done;
                opa       = {32'b0, t_mag};
                opb       = {1'b0, sl_mag};
            end
            default: val_raddr = j_reg;
        endcase
    end

    vlr_ram #(.WIDTH(32), .DEPTH(RING_CELLS)) u_val_ram (
        .clk(clk), .we(accept), .waddr(fill_reg[AW-1:0]), .wdata(cell_value),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    vlr_ram #(.WIDTH(32), .DEPTH(RING_CELLS)) u_vel_ram (
        .clk(clk), .we(accept), .waddr(fill_reg[AW-1:0]), .wdata(cell_velocity),
        .raddr(j_reg), .rdata(vel_rdata)
    );

    vlr_ram #(.WIDTH(32), .DEPTH(RING_CELLS)) u_slp_ram (
        .clk(clk), .we(slp_we), .waddr(j_reg), .wdata(slp_wdata),
        .raddr(slp_raddr), .rdata(slp_rdata)
    );

    vlr_arith u_arith (
        .clk(clk), .rst_n(rst_n), .req(req), .opa(opa), .opb(opb),
        .done(ar_done), .result(ar_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            j_reg         <= '0;
            cw_reg        <= 31'd65536;
            icw_reg       <= 31'd65536;
            dt_reg        <= 31'd65536;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    vlr_pkg::REG_CELL_WIDTH:     cw_reg  <= cfg_data[30:0];
                    vlr_pkg::REG_INV_CELL_WIDTH: icw_reg <= cfg_data[30:0];
                    vlr_pkg::REG_TIME_STEP:      dt_reg  <= cfg_data[30:0];
                    default:                     dt_reg  <= dt_reg;
                endcase
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        fill_reg <= fill_next;
                        if (last_cell || fill_next == CW'(RING_CELLS))
                        begin
                            j_reg     <= '0;
                            state_reg <= S_SL_A;
                        end
                    end
                end
                S_SL_A: state_reg <= S_SL_B;
                S_SL_B:
                begin
                    qm_reg    <= val_rdata;
                    state_reg <= S_SL_C;
                end
                S_SL_C:
                begin
                    qc_reg    <= val_rdata;
                    state_reg <= S_SL_D;
                end
                S_SL_D:
                begin
                    ok_reg    <= (dm > 33'sd0 && dp > 33'sd0) || (dm < 33'sd0 && dp < 33'sd0);
                    neg_reg   <= dm[32];
                    um_reg    <= dm[32] ? 33'(-dm) : dm;
                    up_reg    <= dp[32] ? 33'(-dp) : dp;
                    state_reg <= S_SL_E;
                end
                S_SL_E:
                begin
                    if (ok_reg)
                    begin
                        state_reg <= S_SL_MUL1;
                    end
                    else if (j_last)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_FA_A;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SL_A;
                    end
                end
                S_SL_MUL1: state_reg <= ar_done ? S_SL_DIV : S_SL_MUL1;
                S_SL_DIV:  state_reg <= ar_done ? S_SL_MUL2 : S_SL_DIV;
                S_SL_MUL2:
                begin
                    if (ar_done)
                    begin
                        j_reg     <= j_last ? '0 : j_reg + 1'b1;
                        state_reg <= j_last ? S_FA_A : S_SL_A;
                    end
                end
                S_FA_A: state_reg <= S_FA_B;
                S_FA_B:
                begin
                    v_reg     <= vel_rdata;
                    qm_reg    <= val_rdata;
                    sm_reg    <= slp_rdata;
                    state_reg <= S_FA_C;
                end
                S_FA_C:
                begin
                    qc_reg    <= val_rdata;
                    sc_reg    <= slp_rdata;
                    state_reg <= S_FA_KSI;
                end
                S_FA_KSI:
                begin
                    if (ar_done)
                    begin
                        base_reg  <= ksi_pos ? qm_reg : qc_reg;
                        neg_reg   <= face_neg;
                        state_reg <= S_FA_MUL;
                    end
                end
                S_FA_MUL:
                begin
                    if (ar_done)
                    begin
                        out_face_reg  <= face_sum;
                        out_idx_reg   <= 6'(j_reg);
                        out_last_reg  <= j_last;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_FA_OUT;
                    end
                end
                S_FA_OUT:
                begin
                    if (!face_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (j_last)
                        begin
                            fill_reg  <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_FA_A;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign face_valid = out_valid_reg;
    assign face_value = out_face_reg;
    assign cell_index = out_idx_reg;
    assign last_face  = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(RING_CELLS))
        else $error("fill count beyond ring size");

    a_index_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid |-> (CW'(cell_index) < fill_reg))
        else $error("face index outside the loaded ring");

    a_ring_done: assert property (@(posedge clk) disable iff (!rst_n)
        (face_valid && !face_stall && last_face) |=> (fill_reg == '0 && !cell_stall))
        else $error("ring not released after final face beat");

endmodule

### test/tb_van_leer_ring_face_values.sv
// Self-checking testbench for the van Leer ring face value block, with its own predictor.
`timescale 1ns / 1ps

module tb_van_leer_ring_face_values;

    localparam int NCELLS    = 64;
    localparam int ITEM_GOAL = 380;
    localparam int QUIET_AT  = 320;
    localparam int LIMIT     = 60000;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] velocity;
        logic               last;
        logic               typed;
        logic signed [31:0] face;
    } cell_row_t;

    typedef struct {
        logic signed [31:0] face;
        logic [5:0]         idx;
        logic               last;
    } face_t;

    logic               clk;
    logic               rst_n;
    logic               cell_valid;
    logic               cell_stall;
    logic signed [31:0] cell_value;
    logic signed [31:0] cell_velocity;
    logic               last_cell;
    logic               face_valid;
    logic               face_stall = 1'b0;
    logic signed [31:0] face_value;
    logic [5:0]         cell_index;
    logic               last_face;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    logic signed [31:0] ring_q[NCELLS];
    logic signed [31:0] ring_v[NCELLS];
    logic signed [31:0] slopes[NCELLS];
    int                 ring_fill = 0;
    logic [30:0]        dx_reg = 31'd65536;
    logic [30:0]        inv_dx_reg = 31'd65536;
    logic [30:0]        dt_reg = 31'd65536;
    face_t              faces_due[$];
    logic               typed_pending;
    logic signed [31:0] typed_face;
    int                 errors = 0;
    int                 cells_sent;
    int                 rings_sent;
    int                 faces_checked = 0;
    int                 idle_cycles = 0;
    logic               quiet;
    cell_row_t          dir_rows[16];

    van_leer_ring_face_values u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_valid    (cell_valid),
        .cell_stall    (cell_stall),
        .cell_value    (cell_value),
        .cell_velocity (cell_velocity),
        .last_cell     (last_cell),
        .face_valid    (face_valid),
        .face_stall    (face_stall),
        .face_value    (face_value),
        .cell_index    (cell_index),
        .last_face     (last_face),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint          p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p  = longint'((ma * mb) >> 16);
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint harmonic_slope(input longint dm, input longint dp);
        longint unsigned um;
        longint unsigned up;
        longint unsigned h;
        longint          s;
        if (!((dm > 0 && dp > 0) || (dm < 0 && dp < 0)))
        begin
            return 0;
        end
        um = (dm < 0) ? -dm : dm;
        up = (dp < 0) ? -dp : dp;
        h  = (um * up) / (um + up);
        s  = fixed_mul(longint'(h), longint'(inv_dx_reg));
        return sat32((dm < 0) ? -s : s);
    endfunction

    // Computes and queues the ring's faces in cell order; a pending typed face replaces the last.
    function automatic void predict_ring_faces();
        int     n;
        int     jm;
        int     jp;
        longint ksi;
        longint dx;
        longint fv;
        face_t  f;
        n = ring_fill;
        for (int j = 0; j < n; j++)
        begin
            jm = (j == 0) ? n - 1 : j - 1;
            jp = (j + 1 == n) ? 0 : j + 1;
            slopes[j] = 32'(harmonic_slope(longint'(ring_q[j]) - longint'(ring_q[jm]),
                                           longint'(ring_q[jp]) - longint'(ring_q[j])));
        end
        dx = longint'(dx_reg);
        for (int j = 0; j < n; j++)
        begin
            jm  = (j == 0) ? n - 1 : j - 1;
            ksi = sat32(fixed_mul(longint'(ring_v[j]), longint'(dt_reg)));
            if (ksi > 0)
            begin
                fv = longint'(ring_q[jm]) + fixed_mul(dx - ksi, longint'(slopes[jm]));
            end
            else
            begin
                fv = longint'(ring_q[j]) - fixed_mul(dx + ksi, longint'(slopes[j]));
            end
            f.face = 32'(sat32(fv));
            f.idx  = 6'(j);
            f.last = (j + 1 == n);
            faces_due.push_back(f);
        end
        if (typed_pending)
        begin
            faces_due[faces_due.size() - 1].face = typed_face;
        end
        ring_fill = 0;
    endfunction

    always @(posedge clk)
    begin
        face_t f;
        logic  moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    vlr_pkg::REG_CELL_WIDTH:     dx_reg     = cfg_data[30:0];
                    vlr_pkg::REG_INV_CELL_WIDTH: inv_dx_reg = cfg_data[30:0];
                    vlr_pkg::REG_TIME_STEP:      dt_reg     = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cell_valid && !cell_stall)
            begin
                moved = 1'b1;
                ring_q[ring_fill] = cell_value;
                ring_v[ring_fill] = cell_velocity;
                ring_fill = ring_fill + 1;
                if (last_cell || ring_fill == NCELLS)
                begin
                    predict_ring_faces();
                end
            end
            if (face_valid && !face_stall)
            begin
                moved = 1'b1;
                if (faces_due.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                    begin
                        $display("Unexpected face beat: value %0d index %0d last %0b",
                                 face_value, cell_index, last_face);
                    end
                end
                else
                begin
                    f = faces_due.pop_front();
                    faces_checked = faces_checked + 1;
                    if (face_value !== f.face || cell_index !== f.idx || last_face !== f.last)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                        begin
                            $display("Face mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                     f.face, f.idx, f.last, face_value, cell_index, last_face);
                        end
                    end
                end
            end
            if (moved)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles > LIMIT)
            begin
                $display("Watchdog expired with %0d faces outstanding.", faces_due.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        int hold;
        if (!rst_n || quiet)
        begin
            face_stall <= 1'b0;
        end
        else if (hold > 0)
        begin
            hold = hold - 1;
            face_stall <= (hold > 0);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            hold = $urandom_range(1, 18);
            face_stall <= 1'b1;
        end
        else
        begin
            face_stall <= 1'b0;
        end
    end

    task automatic send_cell(input logic signed [31:0] q, input logic signed [31:0] v,
                             input logic last);
        cell_valid    <= 1'b1;
        cell_value    <= q;
        cell_velocity <= v;
        last_cell     <= last;
        do
        begin
            @(posedge clk);
        end
        while (cell_stall);
        cells_sent = cells_sent + 1;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cell_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic configure(input logic [31:0] dx, input logic [31:0] inv_dx,
                             input logic [31:0] dt);
        cell_valid <= 1'b0;
        while (faces_due.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        write_reg(vlr_pkg::REG_CELL_WIDTH, dx);
        write_reg(vlr_pkg::REG_INV_CELL_WIDTH, inv_dx);
        write_reg(vlr_pkg::REG_TIME_STEP, dt);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    initial
    begin
        int n;
        int rows_done;
        rst_n         = 1'b0;
        cell_valid    = 1'b0;
        cell_value    = '0;
        cell_velocity = '0;
        last_cell     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = vlr_pkg::REG_CELL_WIDTH;
        cfg_data      = '0;
        typed_pending = 1'b0;
        typed_face    = '0;
        cells_sent    = 0;
        rings_sent    = 0;
        quiet         = 1'b0;
        dir_rows = '{
            '{32'h7FFF_FFFF, 32'sd0, 1'b1, 1'b1, 32'h7FFF_FFFF},
            '{32'h8000_0000, 32'h0001_2345, 1'b1, 1'b1, 32'h8000_0000},
            '{32'sd65536, 32'sd65536, 1'b0, 1'b0, 32'sd0},
            '{-32'sd65536, -32'sd65536, 1'b1, 1'b0, 32'sd0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'sd0},
            '{32'sd0, 32'h8000_0000, 1'b0, 1'b0, 32'sd0},
            '{32'h7FFF_FFFF, 32'sd1, 1'b1, 1'b0, 32'sd0},
            '{32'sd0, 32'sd20000, 1'b0, 1'b0, 32'sd0},
            '{32'sd10000, -32'sd20000, 1'b0, 1'b0, 32'sd0},
            '{32'sd30000, 32'sd0, 1'b0, 1'b0, 32'sd0},
            '{32'sd60000, 32'sd30000, 1'b1, 1'b0, 32'sd0},
            '{32'sd5, 32'sd70000, 1'b0, 1'b0, 32'sd0},
            '{32'sd5, -32'sd70000, 1'b0, 1'b0, 32'sd0},
            '{-32'sd7, 32'sd100, 1'b0, 1'b0, 32'sd0},
            '{32'sd3, -32'sd1, 1'b0, 1'b0, 32'sd0},
            '{32'sd9, 32'sd65536, 1'b1, 1'b0, 32'sd0}
        };
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 16; i++)
        begin
            if (dir_rows[i].typed && faces_due.size() != 0)
            begin
                cell_valid <= 1'b0;
                while (faces_due.size() != 0) @(negedge clk);
            end
            typed_pending = dir_rows[i].typed;
            typed_face    = dir_rows[i].face;
            send_cell(dir_rows[i].value, dir_rows[i].velocity, dir_rows[i].last);
            if (dir_rows[i].typed)
            begin
                cell_valid <= 1'b0;
                while (faces_due.size() != 0) @(negedge clk);
                typed_pending = 1'b0;
            end
            if (dir_rows[i].last)
            begin
                rings_sent = rings_sent + 1;
            end
        end

        rows_done = 0;
        while (cells_sent < ITEM_GOAL)
        begin
            case (rows_done)
                0: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: configure(32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
                5: configure(32'h8000_0000, 32'h0001_0000, 32'h8000_4000);
                8: configure(32'h0000_8000, 32'h0002_0000, 32'h0000_C000);
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        configure($urandom_range(0, 32'h0004_0000) | ($urandom_range(0, 1) << 31),
                                  $urandom_range(1, 32'h0004_0000) | ($urandom & 32'h8000_0000),
                                  ($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 32'h0002_0000));
                    end
                end
            endcase
            quiet = (cells_sent >= QUIET_AT);
            case ($urandom_range(0, 11))
                0:       n = NCELLS + 1;
                1:       n = $urandom_range(1, 2);
                2:       n = $urandom_range(20, NCELLS);
                default: n = $urandom_range(3, 10);
            endcase
            for (int j = 0; j < n && j < NCELLS; j++)
            begin
                send_cell(random_value(), random_value(), (j + 1 == n));
            end
            rings_sent = rings_sent + 1;
            rows_done = rows_done + 1;
        end
        cell_valid <= 1'b0;
        while (faces_due.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Sent %0d cells in %0d rings, ring lengths 1 to %0d, several register settings.",
                 cells_sent, rings_sent, NCELLS);
        $display("Checked %0d face beats with random stalls on both channels.", faces_checked);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("Mismatch count: %0d", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
src/vlr_pkg.sv
src/vlr_ram.sv
src/vlr_arith.sv
src/van_leer_ring_face_values.sv
test/tb_van_leer_ring_face_values.sv
